// ===== src/assert_macros.svh =====
// Assertion macros shared by the LCD line timing block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LLTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lltm: same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define LLTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lltm: next-cycle implication failed");

`endif

// ===== src/lltm_pkg.sv =====
// Shared types and timing constants for the LCD line timing block.
// No dependencies.
package lltm_pkg;

    localparam int LINE_W = 8;
    localparam int CD_W   = 10;
    localparam int CYC_W  = 8;

    localparam logic [CD_W-1:0] LINE_CYCLES   = 10'd456;
    localparam logic [CD_W-1:0] OAM_CYCLES    = 10'd80;
    localparam logic [CD_W-1:0] DRAW_CYCLES   = 10'd172;
    localparam logic [CD_W-1:0] OAM_START     = LINE_CYCLES - OAM_CYCLES;
    localparam logic [CD_W-1:0] DRAW_START    = LINE_CYCLES - OAM_CYCLES - DRAW_CYCLES;
    localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;
    localparam logic [LINE_W-1:0] WRAP_LINE     = 8'd153;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } lcd_mode_t;

    typedef enum logic [2:0] {
        REG_DISPLAY_EN  = 3'd0,
        REG_HBLANK_IE   = 3'd1,
        REG_VBLANK_IE   = 3'd2,
        REG_OAM_IE      = 3'd3,
        REG_COMPARE_IE  = 3'd4,
        REG_COMPARE_LN  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic              display_enable;
        logic              hblank_irq_enable;
        logic              vblank_irq_enable;
        logic              oam_irq_enable;
        logic              compare_irq_enable;
        logic [LINE_W-1:0] compare_line;
    } cfg_t;

    typedef struct packed {
        lcd_mode_t         mode;
        logic [LINE_W-1:0] line;
        logic              coincidence;
        logic              status_irq;
        logic              vblank_irq;
        logic              draw_request;
    } result_t;

endpackage

// ===== src/lltm_cfg.sv =====
// Configuration register file of the LCD line timing block.
// Depends on lltm_pkg.
module lltm_cfg
    import lltm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [7:0]  wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_DISPLAY_EN:  cfg_next.display_enable     = wr_data[0];
                REG_HBLANK_IE:   cfg_next.hblank_irq_enable  = wr_data[0];
                REG_VBLANK_IE:   cfg_next.vblank_irq_enable  = wr_data[0];
                REG_OAM_IE:      cfg_next.oam_irq_enable     = wr_data[0];
                REG_COMPARE_IE:  cfg_next.compare_irq_enable = wr_data[0];
                REG_COMPARE_LN:  cfg_next.compare_line       = wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // display on after reset, everything else clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{display_enable: 1'b1, default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/lltm_core.sv =====
// Line/mode state and the single-pass tick update of the LCD timing block.
// Depends on lltm_pkg.
module lltm_core
    import lltm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [CYC_W-1:0] cycles,
    input  cfg_t             cfg,
    output result_t          result
);

    logic [LINE_W-1:0] line_count_reg, line_count_next;
    logic [CD_W-1:0]   countdown_reg, countdown_next;
    lcd_mode_t         mode_state_reg, mode_state_next;
    logic              coin_reg, coin_next;

    lcd_mode_t         cur_mode;
    logic              want_irq;
    logic              line_match;
    logic [CD_W:0]     diff;
    logic              expired;
    logic [LINE_W-1:0] line_inc;

    always_comb
    begin
        line_count_next = line_count_reg;
        countdown_next  = countdown_reg;
        mode_state_next = mode_state_reg;
        coin_next       = coin_reg;
        result          = '0;
        cur_mode        = MODE_HBLANK;
        want_irq        = 1'b0;
        line_match      = (line_count_reg == cfg.compare_line);
        diff            = {1'b0, countdown_reg} - {{(CD_W+1-CYC_W){1'b0}}, cycles};
        expired         = diff[CD_W] || (diff == '0);
        line_inc        = line_count_reg + 1'b1;

        if (!cfg.display_enable)
        begin
            line_count_next    = '0;
            countdown_next     = LINE_CYCLES;
            mode_state_next    = MODE_VBLANK;
            result.mode        = MODE_VBLANK;
            result.line        = '0;
            result.coincidence = coin_reg;
        end
        else
        begin
            priority if (line_count_reg >= VISIBLE_LINES)
            begin
                cur_mode = MODE_VBLANK;
                want_irq = cfg.vblank_irq_enable;
            end
            else if (countdown_reg >= OAM_START)
            begin
                cur_mode = MODE_OAM;
                want_irq = cfg.oam_irq_enable;
            end
            else if (countdown_reg >= DRAW_START)
            begin
                cur_mode = MODE_DRAW;
            end
            else
            begin
                cur_mode = MODE_HBLANK;
                want_irq = cfg.hblank_irq_enable;
            end

            mode_state_next    = cur_mode;
            coin_next          = line_match;
            result.mode        = cur_mode;
            result.coincidence = line_match;
            result.status_irq  = (want_irq && (cur_mode != mode_state_reg))
                               || (line_match && cfg.compare_irq_enable);

            if (expired)
            begin
                countdown_next  = LINE_CYCLES;
                line_count_next = line_inc;
                priority if (line_inc == VISIBLE_LINES)
                    result.vblank_irq = 1'b1;
                else if (line_inc >= WRAP_LINE)
                    line_count_next = '0;
                else if (line_inc < VISIBLE_LINES)
                    result.draw_request = 1'b1;
                else
                    line_count_next = line_inc;
            end
            else
            begin
                countdown_next = diff[CD_W-1:0];
            end
            result.line = line_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
            countdown_reg  <= LINE_CYCLES;
            mode_state_reg <= MODE_HBLANK;
            coin_reg       <= 1'b0;
        end
        else if (step)
        begin
            line_count_reg <= line_count_next;
            countdown_reg  <= countdown_next;
            mode_state_reg <= mode_state_next;
            coin_reg       <= coin_next;
        end
    end

endmodule

// ===== src/lltm_top_dummy_placeholder_unused.sv =====
// Register stage helper: input word register for the LCD timing block.
// Depends on lltm_pkg.
module lltm_in_stage
    import lltm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             drain,
    input  logic [CYC_W-1:0] cycles_in,
    output logic             valid,
    output logic [CYC_W-1:0] cycles_out
);

    logic             valid_reg;
    logic [CYC_W-1:0] cycles_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (drain)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cycles_reg <= cycles_in;
    end

    assign valid      = valid_reg;
    assign cycles_out = cycles_reg;

endmodule

// ===== src/lcd_line_timing_status.sv =====
// LCD line timing and status block, top level.
// Uses lltm_pkg, lltm_cfg, lltm_in_stage, lltm_core and assert_macros.svh.
//
// Channels:
//   tick   : tick_valid / tick_stall with cycles, one word per elapsed-cycle tick.
//   result : res_valid / res_stall with mode, line, coincidence, status_irq,
//            vblank_irq, draw_request; exactly one result word per tick word.
//   cfg    : cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
//            always high. Write only while the block is idle.
// Flow: a tick word accepted into the input register is evaluated and lands
//   in the result register on advance; res_valid is high until that word is
//   taken. Throughput is one word per cycle while res_stall does not hold the
//   result; the single compare/subtract pass lies between the two registers.
// Reset: line 0, countdown 456, mode state 0, display on, interrupts off,
//   both word registers empty.
// Stall: while res_stall holds a waiting result, one more tick word can be
//   taken into the input register; then tick_stall rises until the result
//   is taken. No word is lost or repeated.
module lcd_line_timing_status
    import lltm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // tick channel
    input  logic             tick_valid,
    output logic             tick_stall,
    input  logic [CYC_W-1:0] cycles,
    // result channel
    output logic             res_valid,
    input  logic             res_stall,
    output logic [1:0]       mode,
    output logic [LINE_W-1:0] line,
    output logic             coincidence,
    output logic             status_irq,
    output logic             vblank_irq,
    output logic             draw_request,
    // configuration channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [7:0]       cfg_data
);

`include "assert_macros.svh"

    cfg_t             cfg;
    logic             s1_valid;
    logic [CYC_W-1:0] s1_cycles;
    logic             advance;
    logic             tick_take;
    result_t          core_result;
    result_t          res_reg;
    logic             res_valid_reg;

    assign cfg_ready = 1'b1;

    lltm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Input word moves on when the result register is free or being emptied.
    assign advance    = s1_valid && (!res_valid_reg || !res_stall);
    assign tick_stall = s1_valid && !advance;
    assign tick_take  = tick_valid && !tick_stall;

    lltm_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (tick_take),
        .drain      (advance),
        .cycles_in  (tick_valid ? cycles : s1_cycles),
        .valid      (s1_valid),
        .cycles_out (s1_cycles)
    );

    lltm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .cycles (s1_cycles),
        .cfg    (cfg),
        .result (core_result)
    );

    // Result register: filled on advance, emptied when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= core_result;
    end

    assign res_valid    = res_valid_reg;
    assign mode         = res_reg.mode;
    assign line         = res_reg.line;
    assign coincidence  = res_reg.coincidence;
    assign status_irq   = res_reg.status_irq;
    assign vblank_irq   = res_reg.vblank_irq;
    assign draw_request = res_reg.draw_request;

    // Line never reaches the wrap value once reported.
    `LLTM_ASSERT_IMP(a_line_range, clk, rst_n, res_valid, line < WRAP_LINE)
    // Vblank and draw requests come from exclusive branches of the line advance.
    `LLTM_ASSERT_IMP(a_irq_excl, clk, rst_n, res_valid, !(vblank_irq && draw_request))
    // Vblank interrupt only on entering the first blank line.
    `LLTM_ASSERT_IMP(a_vbl_line, clk, rst_n, res_valid && vblank_irq, line == VISIBLE_LINES)
    // A stalled input word is evaluated as soon as the result side frees up.
    `LLTM_ASSERT_NEXT(a_no_strand, clk, rst_n, s1_valid && !res_stall, res_valid)

endmodule
